/* sv/dss_pkg.sv */
// Package for the drum step sequencer: sizes, command codes, register indexes and states.
package dss_pkg;

    // Sizes of the pattern store and the time base.
    localparam int NUM_CHANNELS = 8;
    localparam int NUM_FRAMES   = 4;
    localparam int NUM_STEPS    = 16;
    localparam int TIME_BITS    = 32;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FR_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int ST_W   = $clog2(NUM_STEPS);
    localparam int ROWS   = NUM_CHANNELS * NUM_FRAMES;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    // One row holds a hit bit and a two-bit microstep count for every step.
    localparam int WORD_W = NUM_STEPS * 3;
    localparam int PER_W  = 32;
    // Adder width: the larger time or period operand, plus two bits.
    localparam int ALU_W  = ((TIME_BITS > PER_W) ? TIME_BITS : PER_W) + 2;

    localparam int MICRO_MODULUS = 3;
    localparam int BEAT_MASK     = 3;
    localparam logic [2:0] OCT_BAR  = 3'd4;
    localparam logic [2:0] OCT_BEAT = 3'd3;
    localparam logic [2:0] OCT_NONE = 3'd0;

    // Run flag bit positions.
    localparam int RUN_PLAYING = 0;
    localparam int RUN_PAUSE   = 1;
    localparam int RUN_STOP    = 2;

    typedef enum logic [3:0] {
        F_TICK      = 4'd0,
        F_TOGGLE    = 4'd1,
        F_MICRO     = 4'd2,
        F_RECORD    = 4'd3,
        F_CLR_CHAN  = 4'd4,
        F_CLR_ALL   = 4'd5,
        F_START     = 4'd6,
        F_PAUSE     = 4'd7,
        F_STOP_END  = 4'd8
    } t_func;

    typedef enum logic [1:0] {
        CFG_STEP_PERIOD = 2'd0,
        CFG_METRONOME   = 2'd1,
        CFG_ALL_FRAMES  = 2'd2,
        CFG_MUTE_MASK   = 2'd3
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_INC,
        S_T_EL,
        S_T_CMP,
        S_SC_RD,
        S_SC_CHK,
        S_R_EL,
        S_R_INC,
        S_R_MUL,
        S_R_CMP,
        S_EMIT,
        S_E_EL,
        S_E_CMP,
        S_ED_RD0,
        S_ED_GET,
        S_ED_RD,
        S_ED_WR,
        S_DONE
    } t_state;

    // Row of the pattern store for one channel and frame.
    function automatic logic [ROW_W-1:0] row_idx(input logic [CH_W-1:0] c,
                                                 input logic [FR_W-1:0] f);
        return ROW_W'(int'(c) * NUM_FRAMES + int'(f));
    endfunction

endpackage

/* sv/drum_step_sequencer_core.sv */
// Drum step sequencer core: command sequencer, shared adder and pattern store.
//
// Usage: a command beat is taken at a clock edge with start high and busy low.
// The command fields are i_func, i_chan_sel, i_frame_sel and i_step_sel. busy
// stays high while the command is worked on; no new command is taken then.
// Configuration writes use i_cfg_valid, i_cfg_index and i_cfg_data; o_cfg_ready
// is always high and a write lands at the edge where i_cfg_valid is high.
// Triggers of a tick leave as result beats on o_trigger_chan, o_click_octave and
// o_last, each marked by o_result_strobe for exactly one cycle; the receiver
// cannot stall, so one beat leaves per cycle. o_last marks the final one.
// Busy time is set by the single shared adder and the one read port of the
// pattern store: any playing tick that does not pause or stop at pattern end
// scans each of the 8 channels, tests each retrigger and emits its triggers;
// toggle, microstep and playing record commands write one frame or all frames.
// The next command is taken at the edge that ends the first cycle with busy low.
// Result beats are registered from the emit state that follows the last scan step
// and follow back to back; the final beat falls in the first cycle with busy low again.
// Reset (synchronous, active low) clears time, position and run flags, restores
// the register defaults and marks every pattern row empty at once.
module drum_step_sequencer_core
    import dss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_func,
    input  logic [2:0]  i_chan_sel,
    input  logic [1:0]  i_frame_sel,
    input  logic [3:0]  i_step_sel,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_result_strobe,
    output logic [3:0]  o_trigger_chan,
    output logic [2:0]  o_click_octave,
    output logic        o_last
);

    // Configuration registers.
    logic [PER_W-1:0] r_period;
    logic             r_met_en;
    logic             r_all_frames;
    logic [7:0]       r_mute;

    // Sequencer state and run state.
    t_state r_state, n_state;
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] r_last_step;
    logic [TIME_BITS-1:0] r_lrt [NUM_CHANNELS];
    logic [ST_W-1:0]      r_play_step;
    logic [FR_W-1:0]      r_play_frame;
    logic [2:0]           r_run;

    // Latched command.
    t_func            r_func;
    logic [CH_W-1:0]  r_c;
    logic [FR_W-1:0]  r_f;
    logic [ST_W-1:0]  r_s;

    // Working registers.
    logic [ALU_W-1:0]        r_acc;
    logic                    r_bound;
    logic [CH_W-1:0]         r_ch;
    logic [NUM_CHANNELS-1:0] r_live;
    logic                    r_click;
    logic [2:0]              r_click_oct;
    logic [1:0]              r_mdiv;
    logic [ST_W-1:0]         r_tstep;
    logic                    r_vbit;
    logic [1:0]              r_mval;
    logic [FR_W-1:0]         r_j;

    // Pattern store with one valid bit per row.
    logic [WORD_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_valid;
    logic [WORD_W-1:0] r_mem_q;
    logic              r_q_valid;
    logic [ROW_W-1:0]  rd_addr;
    logic [WORD_W-1:0] row_q;
    logic [WORD_W-1:0] wr_word;

    // Result register.
    logic       r_o_strobe;
    logic [3:0] r_o_chan;
    logic [2:0] r_o_oct;
    logic       r_o_last;

    // Shared adder.
    logic [ALU_W-1:0] alu_a, alu_b;
    logic             alu_cin;
    logic [ALU_W:0]   alu_sum;
    logic             alu_carry;

    logic accept;
    logic cur_hit;
    logic [1:0] cur_micro;
    logic live_now;
    logic last_chan;

    // Position advance at a step boundary.
    logic [ST_W-1:0] adv_step;
    logic [FR_W-1:0] adv_frame;
    logic            adv_stop;

    // Emission selection.
    logic [NUM_CHANNELS-1:0] low_bit;
    logic [CH_W-1:0]         low_idx;
    logic                    any_live;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign alu_sum   = {1'b0, alu_a} + {1'b0, alu_b} + (ALU_W+1)'(alu_cin);
    assign alu_carry = alu_sum[ALU_W];

    assign row_q     = r_q_valid ? r_mem_q : '0;
    assign cur_hit   = row_q[r_play_step];
    assign cur_micro = row_q[NUM_STEPS + 2*int'(r_play_step) +: 2];
    assign live_now  = cur_hit && !r_mute[r_ch];
    assign last_chan = (int'(r_ch) == NUM_CHANNELS - 1);

    // Next position after a boundary, and whether the pattern end stops play.
    always_comb begin
        adv_step  = r_play_step + ST_W'(1);
        adv_frame = r_play_frame;
        adv_stop  = 1'b0;
        if (int'(r_play_step) == NUM_STEPS - 1) begin
            adv_step = '0;
            if (int'(r_play_frame) == NUM_FRAMES - 1) begin
                adv_frame = '0;
                adv_stop  = r_run[RUN_STOP];
            end else begin
                adv_frame = r_play_frame + FR_W'(1);
            end
        end
    end

    // Lowest pending channel for the next trigger.
    always_comb begin
        low_bit = r_live & (~r_live + NUM_CHANNELS'(1));
        low_idx = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (low_bit[i]) begin
                low_idx = CH_W'(i);
            end
        end
        any_live = (r_live != '0);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_func'(i_func))
                        F_TICK:   n_state = S_T_INC;
                        F_TOGGLE: n_state = S_ED_RD0;
                        F_MICRO:  n_state = S_ED_RD0;
                        F_RECORD: n_state = r_run[RUN_PLAYING] ? S_E_EL : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_T_INC: n_state = r_run[RUN_PLAYING] ? S_T_EL : S_DONE;
            S_T_EL:  n_state = S_T_CMP;
            S_T_CMP: begin
                if (!alu_carry) begin
                    n_state = S_SC_RD;
                end else if (r_run[RUN_PAUSE] || adv_stop) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SC_RD;
                end
            end
            S_SC_RD: n_state = S_SC_CHK;
            S_SC_CHK: begin
                if (!r_bound && live_now) begin
                    n_state = S_R_EL;
                end else begin
                    n_state = last_chan ? S_EMIT : S_SC_RD;
                end
            end
            S_R_EL:  n_state = S_R_INC;
            S_R_INC: n_state = S_R_MUL;
            S_R_MUL: n_state = S_R_CMP;
            S_R_CMP: n_state = last_chan ? S_EMIT : S_SC_RD;
            S_EMIT: begin
                if (r_click) begin
                    n_state = any_live ? S_EMIT : S_IDLE;
                end else if ((r_live & ~low_bit) == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_E_EL:   n_state = S_E_CMP;
            S_E_CMP:  n_state = S_ED_RD;
            S_ED_RD0: n_state = S_ED_GET;
            S_ED_GET: n_state = S_ED_RD;
            S_ED_RD:  n_state = S_ED_WR;
            S_ED_WR: begin
                if (r_all_frames && (int'(r_j) != NUM_FRAMES - 1)) begin
                    n_state = S_ED_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Adder operands and store read address for each step.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        rd_addr = row_idx(r_ch, r_play_frame);
        case (r_state)
            S_T_INC: begin
                alu_a   = ALU_W'(r_time);
                alu_cin = 1'b1;
            end
            S_T_EL, S_E_EL: begin
                alu_a   = ALU_W'(r_time);
                alu_b   = ALU_W'(~r_last_step);
                alu_cin = 1'b1;
            end
            S_T_CMP: begin
                alu_a   = r_acc;
                alu_b   = ~ALU_W'(r_period);
                alu_cin = 1'b1;
            end
            S_R_EL: begin
                alu_a   = ALU_W'(r_time);
                alu_b   = ALU_W'(~r_lrt[r_ch]);
                alu_cin = 1'b1;
            end
            S_R_INC: begin
                alu_a   = r_acc;
                alu_cin = 1'b1;
            end
            S_R_MUL: begin
                // Elapsed-plus-one times the division count, by shift and add.
                case (r_mdiv)
                    2'd1:    alu_a = r_acc << 1;
                    2'd2: begin
                        alu_a = r_acc << 1;
                        alu_b = r_acc;
                    end
                    default: alu_a = r_acc;
                endcase
            end
            S_R_CMP: begin
                alu_a = r_acc;
                alu_b = ~ALU_W'(r_period);
            end
            S_E_CMP: begin
                alu_a = r_acc;
                alu_b = ~ALU_W'(r_period >> 1);
            end
            S_ED_RD0: rd_addr = row_idx(r_c, r_f);
            S_ED_RD:  rd_addr = row_idx(r_c, r_j);
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // Modified row for an edit write.
    always_comb begin
        wr_word = row_q;
        wr_word[r_tstep] = r_vbit;
        if (r_func == F_MICRO) begin
            wr_word[NUM_STEPS + 2*int'(r_tstep) +: 2] = r_mval;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= PER_W'(1000);
            r_met_en     <= 1'b0;
            r_all_frames <= 1'b1;
            r_mute       <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_STEP_PERIOD: r_period     <= i_cfg_data;
                CFG_METRONOME:   r_met_en     <= i_cfg_data[0];
                CFG_ALL_FRAMES:  r_all_frames <= i_cfg_data[0];
                CFG_MUTE_MASK:   r_mute       <= i_cfg_data[7:0];
                default:         r_mute       <= r_mute;
            endcase
        end
    end

    // Time, position, run flags and retrigger times.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_last_step  <= '0;
            r_play_step  <= '0;
            r_play_frame <= '0;
            r_run        <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_lrt[i] <= '0;
            end
        end else begin
            if (accept) begin
                case (t_func'(i_func))
                    F_START:    r_run[RUN_PLAYING] <= 1'b1;
                    F_PAUSE:    r_run[RUN_PAUSE]   <= 1'b1;
                    F_STOP_END: r_run[RUN_STOP]    <= 1'b1;
                    default:    r_run              <= r_run;
                endcase
            end
            if (r_state == S_T_INC) begin
                r_time <= alu_sum[TIME_BITS-1:0];
            end
            // At a boundary every reference time restarts from now.
            if ((r_state == S_T_CMP) && alu_carry) begin
                r_last_step <= r_time;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    r_lrt[i] <= r_time;
                end
                if (r_run[RUN_PAUSE]) begin
                    r_run[RUN_PLAYING] <= 1'b0;
                    r_run[RUN_PAUSE]   <= 1'b0;
                end else begin
                    r_play_step  <= adv_step;
                    r_play_frame <= adv_frame;
                    if (adv_stop) begin
                        r_run[RUN_PLAYING] <= 1'b0;
                        r_run[RUN_STOP]    <= 1'b0;
                    end
                end
            end
            if ((r_state == S_R_CMP) && alu_carry) begin
                r_lrt[r_ch] <= r_time;
            end
        end
    end

    // Command latch and working registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_c    <= CH_W'(i_chan_sel);
            r_f    <= FR_W'(i_frame_sel);
            r_s    <= ST_W'(i_step_sel);
        end
        case (r_state)
            S_T_EL, S_E_EL, S_R_EL: r_acc <= ALU_W'(alu_sum[TIME_BITS-1:0]);
            S_R_INC, S_R_MUL:       r_acc <= alu_sum[ALU_W-1:0];
            S_T_CMP: begin
                r_bound <= alu_carry;
                r_ch    <= '0;
                r_live  <= '0;
                r_click <= 1'b0;
                if (alu_carry && r_met_en) begin
                    if (adv_step == '0) begin
                        r_click     <= 1'b1;
                        r_click_oct <= OCT_BAR;
                    end else if ((int'(adv_step) & BEAT_MASK) == 0) begin
                        r_click     <= 1'b1;
                        r_click_oct <= OCT_BEAT;
                    end
                end
            end
            S_SC_CHK: begin
                if (r_bound) begin
                    r_live[r_ch] <= live_now;
                end
                r_mdiv <= cur_micro;
                if (r_bound || !live_now) begin
                    r_ch <= r_ch + CH_W'(1);
                end
            end
            S_R_CMP: begin
                r_live[r_ch] <= alu_carry;
                r_ch         <= r_ch + CH_W'(1);
            end
            S_EMIT: begin
                if (r_click) begin
                    r_click <= 1'b0;
                end else begin
                    r_live <= r_live & ~low_bit;
                end
            end
            S_E_CMP: begin
                r_vbit <= 1'b1;
                r_j    <= r_all_frames ? FR_W'(0) : r_f;
                if (alu_carry && (int'(r_play_step) == NUM_STEPS - 1)) begin
                    r_tstep <= '0;
                end else begin
                    r_tstep <= r_play_step + ST_W'(alu_carry);
                end
            end
            S_ED_GET: begin
                r_tstep <= r_s;
                r_j     <= r_all_frames ? FR_W'(0) : r_f;
                r_vbit  <= (r_func == F_TOGGLE) ? !row_q[r_s] : 1'b1;
                if (int'(row_q[NUM_STEPS + 2*int'(r_s) +: 2]) >= MICRO_MODULUS - 1) begin
                    r_mval <= 2'd0;
                end else begin
                    r_mval <= row_q[NUM_STEPS + 2*int'(r_s) +: 2] + 2'd1;
                end
            end
            S_ED_WR: r_j <= r_j + FR_W'(1);
            default: r_acc <= r_acc;
        endcase
    end

    // Row valid bits: set by edit writes, cleared by reset and by the clear commands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else begin
            if (r_state == S_ED_WR) begin
                r_row_valid[row_idx(r_c, r_j)] <= 1'b1;
            end
            if (accept && ((t_func'(i_func) == F_CLR_CHAN) || (t_func'(i_func) == F_CLR_ALL))) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    for (int f = 0; f < NUM_FRAMES; f++) begin
                        if (((t_func'(i_func) == F_CLR_ALL) || (c == int'(i_chan_sel)))
                            && (r_all_frames || (f == int'(i_frame_sel)))) begin
                            r_row_valid[c*NUM_FRAMES + f] <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Pattern store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ED_WR) begin
            r_mem[row_idx(r_c, r_j)] <= wr_word;
        end
        r_mem_q   <= r_mem[rd_addr];
        r_q_valid <= r_row_valid[rd_addr];
    end

    // Result beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_strobe <= 1'b0;
        end else begin
            r_o_strobe <= (r_state == S_EMIT) && (r_click || any_live);
        end
        if (r_click) begin
            r_o_chan <= 4'(NUM_CHANNELS);
            r_o_oct  <= r_click_oct;
            r_o_last <= !any_live;
        end else begin
            r_o_chan <= 4'(low_idx);
            r_o_oct  <= OCT_NONE;
            r_o_last <= ((r_live & ~low_bit) == '0);
        end
    end

    assign o_result_strobe = r_o_strobe;
    assign o_trigger_chan  = r_o_chan;
    assign o_click_octave  = r_o_oct;
    assign o_last          = r_o_last;

    // A result beat only follows the emit step.
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(r_state == S_EMIT))
        else $error("result beat without emit step");

    // An accepted command always makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // The final beat of a tick is not followed by another.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_last) |=> !o_result_strobe)
        else $error("beat after final trigger");

    // A click octave is only ever sent on the metronome channel.
    a_click_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && (o_click_octave != OCT_NONE))
            |-> (o_trigger_chan == 4'(NUM_CHANNELS)))
        else $error("click octave on a pattern channel");

endmodule

/* tb/dss_trigger_checker.sv */
// Checker for the drum step sequencer: watches every channel, predicts triggers and compares them.
module dss_trigger_checker
    import dss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [3:0]  i_func,
    input  logic [2:0]  i_chan_sel,
    input  logic [1:0]  i_frame_sel,
    input  logic [3:0]  i_step_sel,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_result_strobe,
    input  logic [3:0]  i_trigger_chan,
    input  logic [2:0]  i_click_octave,
    input  logic        i_last,
    output int          o_errors,
    output int          o_pending,
    output int          o_commands,
    output int          o_triggers
);

    typedef struct packed {
        logic [3:0] chan;
        logic [2:0] octave;
        logic       last;
    } t_trigger;

    // Expected triggers, oldest first.
    t_trigger trig_q[$];

    // Shadow configuration.
    logic [31:0] period;
    logic        metro_on;
    logic        all_frames;
    logic [7:0]  muted;

    // Shadow sequencer state.
    logic [31:0] now_t;
    logic [31:0] step_t;
    logic [31:0] retrig_t [NUM_CHANNELS];
    logic [3:0]  pos_step;
    logic [1:0]  pos_frame;
    logic        playing, pause_pend, stop_pend;
    logic        hits  [NUM_CHANNELS][NUM_FRAMES][NUM_STEPS];
    logic [1:0]  micro [NUM_CHANNELS][NUM_FRAMES][NUM_STEPS];

    function automatic logic [31:0] since(input logic [31:0] t0);
        return now_t - t0;
    endfunction

    function automatic logic sounding(input int c);
        return !muted[c] && hits[c][pos_frame][pos_step];
    endfunction

    task automatic push_trigger(input int c, input logic [2:0] oct);
        t_trigger t;
        t.chan   = 4'(c);
        t.octave = oct;
        t.last   = 1'b0;
        trig_q.push_back(t);
    endtask

    task automatic clear_row(input int c, input int f);
        for (int s = 0; s < NUM_STEPS; s++) begin
            hits[c][f][s]  = 1'b0;
            micro[c][f][s] = 2'd0;
        end
    endtask

    task automatic clear_chan(input int c, input int f);
        if (all_frames) begin
            for (int j = 0; j < NUM_FRAMES; j++) clear_row(c, j);
        end else begin
            clear_row(c, f);
        end
    endtask

    // One time tick: step boundary or microstep retriggers.
    task automatic run_tick();
        int n0;
        logic [31:0] div;
        n0 = trig_q.size();
        now_t = now_t + 32'd1;
        if (playing) begin
            if (since(step_t) >= period) begin
                if (pause_pend) begin
                    playing    = 1'b0;
                    pause_pend = 1'b0;
                end else begin
                    if (pos_step == 4'(NUM_STEPS - 1)) begin
                        pos_step  = '0;
                        pos_frame = pos_frame + 2'd1;
                        if (pos_frame == 0 && stop_pend) begin
                            playing   = 1'b0;
                            stop_pend = 1'b0;
                        end
                    end else begin
                        pos_step = pos_step + 4'd1;
                    end
                    if (playing) begin
                        if (metro_on) begin
                            if (pos_step == 0) push_trigger(NUM_CHANNELS, OCT_BAR);
                            else if ((pos_step & BEAT_MASK) == 0)
                                push_trigger(NUM_CHANNELS, OCT_BEAT);
                        end
                        for (int c = 0; c < NUM_CHANNELS; c++)
                            if (sounding(c)) push_trigger(c, OCT_NONE);
                    end
                end
                step_t = now_t;
                for (int c = 0; c < NUM_CHANNELS; c++) retrig_t[c] = now_t;
            end else begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (sounding(c)) begin
                        div = 32'(micro[c][pos_frame][pos_step]) + 32'd1;
                        if (since(retrig_t[c]) >= period / div) begin
                            push_trigger(c, OCT_NONE);
                            retrig_t[c] = now_t;
                        end
                    end
                end
            end
        end
        if (trig_q.size() > n0) trig_q[trig_q.size() - 1].last = 1'b1;
    endtask

    // Apply one command beat to the shadow state.
    task automatic apply_command(input logic [3:0] fn, input int c, input int f,
                                 input int s);
        logic [1:0] m;
        int st;
        case (fn)
            F_TICK: begin
                run_tick();
            end
            F_TOGGLE: begin
                hits[c][f][s] = !hits[c][f][s];
                if (all_frames)
                    for (int j = 0; j < NUM_FRAMES; j++) hits[c][j][s] = hits[c][f][s];
            end
            F_MICRO: begin
                m = (micro[c][f][s] == 2'(MICRO_MODULUS - 1)) ? 2'd0 : micro[c][f][s] + 2'd1;
                hits[c][f][s]  = 1'b1;
                micro[c][f][s] = m;
                if (all_frames)
                    for (int j = 0; j < NUM_FRAMES; j++) begin
                        hits[c][j][s]  = 1'b1;
                        micro[c][j][s] = m;
                    end
            end
            F_RECORD: begin
                if (playing) begin
                    st = pos_step;
                    if (since(step_t) > (period >> 1)) st++;
                    if (st >= NUM_STEPS) st = 0;
                    if (all_frames) begin
                        for (int j = 0; j < NUM_FRAMES; j++) hits[c][j][st] = 1'b1;
                    end else begin
                        hits[c][f][st] = 1'b1;
                    end
                end
            end
            F_CLR_CHAN: clear_chan(c, f);
            F_CLR_ALL: begin
                for (int j = 0; j < NUM_CHANNELS; j++) clear_chan(j, f);
            end
            F_START:    playing    = 1'b1;
            F_PAUSE:    pause_pend = 1'b1;
            F_STOP_END: stop_pend  = 1'b1;
            default: ;
        endcase
    endtask

    // All channels are sampled at the clock edge, before the drivers update them.
    always @(posedge i_clk) begin
        t_trigger exp_t;
        if (!i_rst_n) begin
            trig_q.delete();
            period     = 32'd1000;
            metro_on   = 1'b0;
            all_frames = 1'b1;
            muted      = 8'd0;
            now_t      = '0;
            step_t     = '0;
            pos_step   = '0;
            pos_frame  = '0;
            playing    = 1'b0;
            pause_pend = 1'b0;
            stop_pend  = 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                retrig_t[c] = '0;
                for (int f = 0; f < NUM_FRAMES; f++) clear_row(c, f);
            end
            o_errors   = 0;
            o_commands = 0;
            o_triggers = 0;
        end else begin
            // Register write beat.
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_STEP_PERIOD: period     = i_cfg_data;
                    CFG_METRONOME:   metro_on   = i_cfg_data[0];
                    CFG_ALL_FRAMES:  all_frames = i_cfg_data[0];
                    CFG_MUTE_MASK:   muted      = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // Result beat against the oldest expectation.
            if (i_result_strobe) begin
                o_triggers++;
                if (trig_q.size() == 0) begin
                    $error("Unexpected trigger: chan %0d octave %0d last %0d",
                           i_trigger_chan, i_click_octave, i_last);
                    o_errors++;
                end else begin
                    exp_t = trig_q.pop_front();
                    if (i_trigger_chan !== exp_t.chan) begin
                        $error("trigger_chan: expected %0d, got %0d", exp_t.chan,
                               i_trigger_chan);
                        o_errors++;
                    end
                    if (i_click_octave !== exp_t.octave) begin
                        $error("click_octave: expected %0d, got %0d", exp_t.octave,
                               i_click_octave);
                        o_errors++;
                    end
                    if (i_last !== exp_t.last) begin
                        $error("last: expected %0d, got %0d", exp_t.last, i_last);
                        o_errors++;
                    end
                end
            end
            // Command beat.
            if (i_start && !i_busy) begin
                o_commands++;
                apply_command(i_func, i_chan_sel, i_frame_sel, i_step_sel);
            end
        end
        o_pending = trig_q.size();
    end

endmodule

/* tb/tb_drum_step_sequencer_core.sv */
// Testbench top for the drum step sequencer core: stimulus, register phases and verdict.
module tb_drum_step_sequencer_core;
    import dss_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_func;
    logic [2:0]  i_chan_sel;
    logic [1:0]  i_frame_sel;
    logic [3:0]  i_step_sel;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        o_result_strobe;
    logic [3:0]  o_trigger_chan;
    logic [2:0]  o_click_octave;
    logic        o_last;

    int errors, pending, commands, triggers;

    drum_step_sequencer_core dut (.*);

    dss_trigger_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_func(i_func), .i_chan_sel(i_chan_sel), .i_frame_sel(i_frame_sel),
        .i_step_sel(i_step_sel), .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_result_strobe(o_result_strobe), .i_trigger_chan(o_trigger_chan),
        .i_click_octave(o_click_octave), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_commands(commands),
        .o_triggers(triggers)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_func func_unknown(input int code);
        return t_func'(code);
    endfunction

    // Send one command beat; returns at the edge that took it.
    task automatic send_cmd(input t_func fn, input int c, input int f, input int s);
        start       <= 1'b1;
        i_func      <= fn;
        i_chan_sel  <= 3'(c);
        i_frame_sel <= 2'(f);
        i_step_sel  <= 4'(s);
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
    endtask

    // Random pause between beats: mostly none or short, now and then long.
    task automatic idle_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        n = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Let every expected trigger arrive, then allow for a tick still in flight.
    task automatic settle();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] per, input logic met, input logic allf,
                            input logic [7:0] mute);
        write_reg(CFG_STEP_PERIOD, per);
        write_reg(CFG_METRONOME, 32'(met));
        write_reg(CFG_ALL_FRAMES, 32'(allf));
        write_reg(CFG_MUTE_MASK, 32'(mute));
    endtask

    // Random command mix: mostly ticks and edits so playback goes deep.
    task automatic random_cmds(input int count);
        int r;
        t_func fn;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      fn = F_TICK;
            else if (r < 65) fn = F_TOGGLE;
            else if (r < 73) fn = F_MICRO;
            else if (r < 81) fn = F_RECORD;
            else if (r < 84) fn = F_CLR_CHAN;
            else if (r < 85) fn = F_CLR_ALL;
            else if (r < 90) fn = F_START;
            else if (r < 92) fn = F_PAUSE;
            else if (r < 94) fn = F_STOP_END;
            else             fn = t_func'($urandom_range(9, 15));
            send_cmd(fn, $urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 15));
            idle_gap();
        end
    endtask

    initial begin
        start       = 1'b0;
        i_func      = F_TICK;
        i_chan_sel  = '0;
        i_frame_sel = '0;
        i_step_sel  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_STEP_PERIOD;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: shortest period, metronome on, channel 7 muted.
        set_regs(32'd3, 1'b1, 1'b1, 8'h80);
        send_cmd(F_RECORD, 3, 0, 0);
        send_cmd(F_TOGGLE, 0, 0, 1);
        send_cmd(F_MICRO, 1, 3, 1);
        send_cmd(F_MICRO, 1, 3, 1);
        send_cmd(F_MICRO, 2, 1, 2);
        send_cmd(F_TOGGLE, 7, 2, 1);
        send_cmd(F_TOGGLE, 4, 3, 15);
        send_cmd(F_START, 0, 0, 0);
        repeat (8) send_cmd(F_TICK, 0, 0, 0);
        send_cmd(F_RECORD, 5, 2, 0);
        send_cmd(F_CLR_CHAN, 0, 1, 0);
        send_cmd(func_unknown(9), 7, 3, 15);
        send_cmd(func_unknown(15), 0, 0, 0);
        send_cmd(F_PAUSE, 0, 0, 0);
        repeat (4) send_cmd(F_TICK, 0, 0, 0);
        send_cmd(F_STOP_END, 0, 0, 0);
        send_cmd(F_CLR_ALL, 0, 0, 0);
        settle();

        // Random phases over several register settings.
        set_regs(32'd3, 1'b1, 1'b1, 8'h00);
        send_cmd(F_START, 0, 0, 0);
        random_cmds(100);
        settle();
        set_regs(32'($urandom_range(4, 12)), 1'b0, 1'b0, 8'($urandom_range(0, 255)));
        send_cmd(F_START, 0, 0, 0);
        random_cmds(90);
        settle();
        set_regs(32'hFFFF_FFFF, 1'b1, 1'b0, 8'hFF);
        send_cmd(F_START, 0, 0, 0);
        random_cmds(20);
        settle();
        set_regs(32'd4, 1'b1, 1'($urandom_range(0, 1)), 8'h00);
        send_cmd(F_START, 0, 0, 0);
        random_cmds(90);
        settle();

        $display("Run covered %0d command beats and %0d trigger beats", commands, triggers);
        $display("over five register settings, including the period extremes.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #40000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
